// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the queue and back-end RTL files.
// Each macro checks on the rising edge of i_clk while i_rst_n is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every edge.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHK_ALWAYS(lbl, expr, msg)
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/itrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg: shared types and constants
// Beat layouts, job descriptor for the front-to-back queue, digit encoding.
// ----------------------------------------------------------------------------
package itrd_pkg;

    // Digit stack depth; a 31-bit magnitude needs at most 31 digits
    localparam int DIGIT_STORE_DEPTH = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int MAG_W   = VALUE_W - 1;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT   = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO      = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_ALPHA_OFS = CHAR_W'(55);
    localparam logic [CHAR_W-1:0]  ERROR_CODE      = CHAR_W'(0);

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RADIX_W-1:0]        radix;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
        logic              bad_radix;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_BAD_RADIX = 2'd0,
        JOB_ZERO      = 2'd1,
        JOB_CONVERT   = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [MAG_W-1:0]   mag;
        logic [RADIX_W-1:0] radix;
    } t_job;

    // Map a digit 0..35 to '0'..'9', 'A'..'Z'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d7;
        d7 = {1'b0, d};
        if (d < DECIMAL_LIMIT) begin
            return ASCII_ZERO + d7;
        end else begin
            return ASCII_ALPHA_OFS + d7;
        end
    endfunction

endpackage

// ===== hw/rtl/itrd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_queue: job queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itrd_pkg::t_job i_job,
    input  logic           i_pop,
    output itrd_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);

    localparam int PTR_W = $clog2(itrd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(itrd_pkg::QUEUE_DEPTH + 1);

    itrd_pkg::t_job r_slot [itrd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_job   = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(itrd_pkg::QUEUE_DEPTH));

    // Advance a pointer with wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(itrd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end else begin
            return p + 1'b1;
        end
    endfunction

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CHK_ALWAYS(a_no_overflow, !(i_push && o_full), "push into full job queue")
    `CHK_ALWAYS(a_no_underflow, !(i_pop && o_empty), "pop from empty job queue")
    `CHK_ALWAYS(a_count_range, r_count <= CNT_W'(itrd_pkg::QUEUE_DEPTH), "queue count too big")

endmodule

// ===== hw/rtl/itrd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_front: command intake and classification
// Sorts each accepted beat into bad radix, zero/negative or conversion job.
// ----------------------------------------------------------------------------
module itrd_front (
    input  logic               i_start,
    input  itrd_pkg::t_in_item i_in,
    input  logic               i_queue_full,
    output logic               o_busy,
    output logic               o_push,
    output itrd_pkg::t_job     o_job
);

    logic bad_radix;
    logic non_positive;

    // Hold off new commands while the queue is full
    assign o_busy = i_queue_full;
    assign o_push = i_start && !i_queue_full;

    // Classify the incoming beat
    assign bad_radix    = (i_in.radix < itrd_pkg::RADIX_MIN) ||
                          (i_in.radix > itrd_pkg::RADIX_MAX);
    assign non_positive = i_in.value[itrd_pkg::VALUE_W-1] || (i_in.value == '0);

    always_comb begin
        o_job.mag   = i_in.value[itrd_pkg::MAG_W-1:0];
        o_job.radix = i_in.radix;
        if (bad_radix) begin
            o_job.kind = itrd_pkg::JOB_BAD_RADIX;
        end else if (non_positive) begin
            o_job.kind = itrd_pkg::JOB_ZERO;
        end else begin
            o_job.kind = itrd_pkg::JOB_CONVERT;
        end
    end

endmodule

// ===== hw/rtl/itrd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_back: digit generation and emission
// Bit-serial restoring divider pushes remainders onto a digit stack, then the
// stack is popped one digit per cycle, most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itrd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  itrd_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_strobe,
    output itrd_pkg::t_out_item o_result
);

    localparam int DEPTH  = itrd_pkg::DIGIT_STORE_DEPTH;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MAG_W  = itrd_pkg::MAG_W;
    localparam int STEP_W = $clog2(MAG_W);
    localparam int RAD_W  = itrd_pkg::RADIX_W;
    localparam int DIG_W  = itrd_pkg::DIGIT_W;
    localparam int CHR_W  = itrd_pkg::CHAR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [DIG_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W-1:0]  r_dcount, n_dcount;
    logic [RAD_W-1:0]  r_radix, n_radix;
    logic              r_spec_valid, n_spec_valid;
    logic [CHR_W-1:0]  r_spec_code, n_spec_code;
    logic              r_spec_bad, n_spec_bad;
    logic              r_emit_valid, n_emit_valid;
    logic              r_emit_last, n_emit_last;
    logic [DIG_W-1:0]  r_rd_data;

    logic [DIG_W-1:0] mem [DEPTH];
    logic             wr_en;
    logic             rd_en;
    logic [CNT_W-1:0] pop_count;

    logic [DIG_W:0]   rem_shift;
    logic             rem_ge;
    logic [DIG_W:0]   rem_sub;
    logic [DIG_W-1:0] rem_next;
    logic [MAG_W-1:0] quo_next;

    // One restoring division step: shift in next dividend bit, try subtract
    assign rem_shift = {r_rem, r_quo[MAG_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_radix});
    assign rem_sub   = rem_shift - {1'b0, r_radix};
    assign rem_next  = rem_ge ? rem_sub[DIG_W-1:0] : rem_shift[DIG_W-1:0];
    assign quo_next  = {r_quo[MAG_W-2:0], rem_ge};
    assign pop_count = r_dcount - 1'b1;

    // Sequence intake, division and stack pop
    always_comb begin
        n_state      = r_state;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_step       = r_step;
        n_dcount     = r_dcount;
        n_radix      = r_radix;
        n_spec_valid = 1'b0;
        n_spec_code  = r_spec_code;
        n_spec_bad   = r_spec_bad;
        n_emit_valid = 1'b0;
        n_emit_last  = r_emit_last;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.kind)
                        itrd_pkg::JOB_ZERO: begin
                            n_spec_valid = 1'b1;
                            n_spec_code  = itrd_pkg::ASCII_ZERO;
                            n_spec_bad   = 1'b0;
                        end
                        itrd_pkg::JOB_CONVERT: begin
                            n_quo    = i_job.mag;
                            n_rem    = '0;
                            n_step   = '0;
                            n_dcount = '0;
                            n_radix  = i_job.radix;
                            n_state  = S_DIVIDE;
                        end
                        default: begin
                            n_spec_valid = 1'b1;
                            n_spec_code  = itrd_pkg::ERROR_CODE;
                            n_spec_bad   = 1'b1;
                        end
                    endcase
                end
            end
            S_DIVIDE: begin
                n_quo = quo_next;
                n_rem = rem_next;
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    // Digit done: push remainder, restart on the quotient
                    wr_en  = (r_dcount < CNT_W'(DEPTH));
                    n_rem  = '0;
                    n_step = '0;
                    if (wr_en) begin
                        n_dcount = r_dcount + 1'b1;
                    end
                    if (quo_next == '0) begin
                        n_state = S_POP;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_POP: begin
                rd_en        = 1'b1;
                n_dcount     = pop_count;
                n_emit_valid = 1'b1;
                n_emit_last  = (pop_count == '0);
                if (pop_count == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Digit stack with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_dcount[IDX_W-1:0]] <= rem_next;
        end
        if (rd_en) begin
            r_rd_data <= mem[pop_count[IDX_W-1:0]];
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dcount     <= '0;
            r_spec_valid <= 1'b0;
            r_emit_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dcount     <= n_dcount;
            r_spec_valid <= n_spec_valid;
            r_emit_valid <= n_emit_valid;
        end
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_step      <= n_step;
        r_radix     <= n_radix;
        r_spec_code <= n_spec_code;
        r_spec_bad  <= n_spec_bad;
        r_emit_last <= n_emit_last;
    end

    // Drive the result beat
    assign o_strobe           = r_spec_valid || r_emit_valid;
    assign o_result.char_code = r_spec_valid ? r_spec_code
                                             : itrd_pkg::digit_to_ascii(r_rd_data);
    assign o_result.is_last   = r_spec_valid || r_emit_last;
    assign o_result.bad_radix = r_spec_valid && r_spec_bad;

    `CHK_ALWAYS(a_one_source, !(r_spec_valid && r_emit_valid), "two result sources at once")
    `CHK_SAME(a_pop_nonempty, r_state == S_POP, r_dcount != '0, "pop from empty digit stack")
    `CHK_NEXT(a_last_ends, r_emit_valid && r_emit_last, !r_emit_valid, "digit after last digit")
    `CHK_SAME(a_div_radix, r_state == S_DIVIDE, r_radix >= itrd_pkg::RADIX_MIN,
              "division by illegal radix")

endmodule

// ===== hw/rtl/integer_to_radix_digits_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit: signed integer to ASCII digits in radix 2..36
// Converts one command beat into a string of digit beats, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_in (value, radix) with start high; the beat is
//   taken at an edge where busy is low. busy rises only when the two-entry
//   job queue is full.
//   Result channel: o_strobe marks each result beat for exactly one cycle;
//   o_result carries char_code, is_last and bad_radix. The receiver cannot
//   stall, so it must take every strobed beat.
//   A radix outside 2..36 gives one beat with bad_radix set and char_code 0;
//   a value of zero or below gives the single beat '0'. When the back end is
//   idle, either is strobed once the job has passed the queue and the result
//   register. A positive value is divided digit by digit in the bit-serial
//   restoring divider, then the digit stack is popped one digit per cycle;
//   the first digit comes from its registered read, the rest follow on
//   consecutive cycles, last one flagged with is_last. A command holds the
//   back end until its last digit pops, longest at radix 2 with 31 digits.
//   The divider sets the rate. Reset clears the queue and the sequencer.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  itrd_pkg::t_in_item  i_in,
    output logic                o_strobe,
    output itrd_pkg::t_out_item o_result
);

    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    itrd_pkg::t_job push_job;
    itrd_pkg::t_job head_job;

    // Classify command beats
    itrd_front u_front (
        .i_start      (start),
        .i_in         (i_in),
        .i_queue_full (q_full),
        .o_busy       (busy),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Decouple intake from conversion
    itrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Convert and emit digits
    itrd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== tb/integer_to_radix_digits_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit_tb: self-checking bench for the radix converter
// Sends command beats (value, radix) and predicts the ASCII digit string each
// one produces, MSD first with is_last on the final digit. Every strobed
// result beat is checked field by field against the oldest predicted digit.
// Directed tests cover bad radixes, zero and negative values, the value and
// radix extremes and letter digits. A random mix with idle bursts, drain
// pauses and a back-to-back tail follows.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit_tb;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 160;
    localparam int TAIL_ITEMS     = 40;
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int PRINT_LIMIT    = 100;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    itrd_pkg::t_in_item  i_in    = '0;
    logic                o_strobe;
    itrd_pkg::t_out_item o_result;

    // Digits still owed by the block, oldest first
    itrd_pkg::t_out_item pending_chars[$];
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;

    integer_to_radix_digits_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (i_in),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Free-running clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Print one mismatch line and count it
    task automatic note_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Append the digit beats that one command produces
    function automatic void predict_chars(input itrd_pkg::t_in_item cmd);
        int unsigned                  mag;
        int unsigned                  base;
        int                           idx;
        logic [itrd_pkg::DIGIT_W-1:0] digit;
        logic [itrd_pkg::DIGIT_W-1:0] digits[$];
        itrd_pkg::t_out_item          ch;

        ch.bad_radix = 1'b0;
        ch.is_last   = 1'b1;
        if (cmd.radix < itrd_pkg::RADIX_MIN || cmd.radix > itrd_pkg::RADIX_MAX) begin
            ch.char_code = itrd_pkg::ERROR_CODE;
            ch.bad_radix = 1'b1;
            pending_chars.push_back(ch);
            return;
        end
        if (cmd.value[itrd_pkg::VALUE_W-1] || cmd.value == '0) begin
            ch.char_code = itrd_pkg::ASCII_ZERO;
            pending_chars.push_back(ch);
            return;
        end
        // Collect remainders least significant first, then emit reversed
        base = cmd.radix;
        mag  = cmd.value;
        while (mag > 0) begin
            digits.push_back(itrd_pkg::DIGIT_W'(mag % base));
            mag = mag / base;
        end
        for (idx = digits.size() - 1; idx >= 0; idx--) begin
            digit = digits[idx];
            if (digit < itrd_pkg::DECIMAL_LIMIT) begin
                ch.char_code = itrd_pkg::ASCII_ZERO + itrd_pkg::CHAR_W'(digit);
            end else begin
                ch.char_code = itrd_pkg::ASCII_ALPHA_OFS + itrd_pkg::CHAR_W'(digit);
            end
            ch.is_last = (idx == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    // Check each strobed result beat against the oldest predicted digit
    always @(posedge i_clk) begin
        itrd_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected beat char_code=%0d is_last=%0b bad_radix=%0b",
                    o_result.char_code, o_result.is_last, o_result.bad_radix));
            end else begin
                want = pending_chars.pop_front();
                if (o_result.char_code !== want.char_code) begin
                    note_mismatch($sformatf("char_code got %0d want %0d",
                        o_result.char_code, want.char_code));
                end
                if (o_result.is_last !== want.is_last) begin
                    note_mismatch($sformatf("is_last got %0b want %0b",
                        o_result.is_last, want.is_last));
                end
                if (o_result.bad_radix !== want.bad_radix) begin
                    note_mismatch($sformatf("bad_radix got %0b want %0b",
                        o_result.bad_radix, want.bad_radix));
                end
            end
        end
    end

    // Drive one command beat and hold it until the block takes it
    task automatic send_command(input logic signed [itrd_pkg::VALUE_W-1:0] value,
                                input logic [itrd_pkg::RADIX_W-1:0] radix);
        itrd_pkg::t_in_item cmd;
        cmd.value = value;
        cmd.radix = radix;
        start <= 1'b1;
        i_in  <= cmd;
        do @(posedge i_clk); while (busy);
        predict_chars(cmd);
    endtask

    // Drop start for a number of cycles
    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop start until every predicted digit has come back
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // Radix outside 2..36, with assorted values
    task automatic test_bad_radix();
        send_command(32'sh7FFF_FFFF, 6'd0);
        send_command(32'sd1, 6'd1);
        send_command(-32'sd1, 6'd37);
        send_command(32'sd12345, 6'd63);
        wait_drained();
    endtask

    // Zero and negative values give the single digit '0'
    task automatic test_nonpositive();
        send_command(32'sd0, 6'd10);
        send_command(-32'sd1, 6'd2);
        send_command(32'sh8000_0000, 6'd36);
        send_command(32'sd0, 6'd2);
        wait_drained();
    endtask

    // Largest and smallest positive values at the radix extremes
    task automatic test_extremes();
        send_command(32'sh7FFF_FFFF, 6'd2);
        send_command(32'sh7FFF_FFFF, 6'd36);
        send_command(32'sh7FFF_FFFF, 6'd10);
        send_command(32'sd1, 6'd2);
        send_command(32'sd1, 6'd36);
        send_command(32'sd2, 6'd2);
        wait_drained();
    endtask

    // Digits at and above ten map to letters
    task automatic test_letter_digits();
        send_command(32'sd35, 6'd36);
        send_command(32'sd36, 6'd36);
        send_command(32'sh00AB_CDEF, 6'd16);
        send_command(32'sd10, 6'd11);
        send_command(32'sd123456789, 6'd35);
        wait_drained();
    endtask

    // Mostly positive values of random length in a valid radix
    task automatic send_random_command();
        int                                   pick;
        int                                   width;
        logic signed [itrd_pkg::VALUE_W-1:0]  value;
        logic [itrd_pkg::RADIX_W-1:0]         radix;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            radix = ($urandom_range(0, 1) == 0) ? itrd_pkg::RADIX_W'($urandom_range(0, 1))
                                                : itrd_pkg::RADIX_W'($urandom_range(37, 63));
            value = $urandom;
        end else if (pick < 16) begin
            radix = itrd_pkg::RADIX_W'($urandom_range(2, 36));
            value = ($urandom_range(0, 2) == 0) ? '0 : {1'b1, 31'($urandom)};
        end else begin
            case ($urandom_range(0, 5))
                0:       radix = itrd_pkg::RADIX_MIN;
                1:       radix = itrd_pkg::RADIX_MAX;
                default: radix = itrd_pkg::RADIX_W'($urandom_range(2, 36));
            endcase
            width = $urandom_range(1, itrd_pkg::MAG_W);
            value = {1'b0, 31'($urandom) & 31'((32'd1 << width) - 32'd1)};
            if (value == 0) begin
                value = 1;
            end
        end
        send_command(value, radix);
    endtask

    // Random mix with idle bursts, stretches without idling and occasional drains
    task automatic test_random_mix();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ((n % 60) == 59) begin
                wait_drained();
            end else if (((n / 20) % 3) != 2 && $urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 16));
            end
            send_random_command();
        end
        wait_drained();
    endtask

    // Back-to-back commands with no idling
    task automatic test_back_to_back();
        for (int n = 0; n < TAIL_ITEMS; n++) begin
            send_random_command();
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bad_radix();
        test_nonpositive();
        test_extremes();
        test_letter_digits();
        test_random_mix();
        test_back_to_back();

        // Let the last digits come back, then a few quiet cycles
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/itrd_pkg.sv
hw/rtl/itrd_queue.sv
hw/rtl/itrd_front.sv
hw/rtl/itrd_back.sv
hw/rtl/integer_to_radix_digits_unit.sv
tb/integer_to_radix_digits_unit_tb.sv
